// ===== src/tgc_pkg.sv =====
package tgc_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    // Fixed register and field widths
    localparam int DEBOUNCE_W = 16;
    localparam int MIN_TAP_W  = 16;
    localparam int THRESH_W   = 12;
    localparam int STEP_W     = 8;
    localparam int DUR_W      = 16;
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd200;
    localparam logic [MIN_TAP_W-1:0]  MIN_TAP_RST  = 16'd50;
    localparam logic [THRESH_W-1:0]   THRESH_RST   = 12'd20;
    localparam logic [STEP_W-1:0]     STEP_RST     = 8'd20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd3;

    // Touch command codes
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd3;

    // Gesture modes
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DETECTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LR       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UD       = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } tgc_state_t;

endpackage

// ===== src/tgc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tgc_div
    import tgc_pkg::*;
#(
    parameter int NUM_W = COORD_BITS_DEF,
    parameter int DEN_W = STEP_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/touch_gesture_classifier.sv =====
// Touch gesture classifier.
// Input stream: s_tvalid/s_tready, s_tuser = touch command, s_tdata = x, y and
// the millisecond timestamp. One result beat per sample on m_tvalid/m_tready:
// m_tuser flags a tap and/or a swipe report, m_tdata carries the tap fields,
// swipe axis and steps, and the gesture mode after the sample.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 debounce, 1 min tap,
// 2 swipe threshold, 3 step size) and cfg_data; always ready, write while idle.
// Each accepted sample passes through an evaluate state and then an emit state;
// a swipe move runs the serial divider between the two.
// s_tready is low from acceptance until the result is loaded into the output
// register; the next sample may enter while that result still waits.
// If the receiver stalls, the result holds in m_tdata/m_tuser and the next
// sample stalls in its emit cycle until the output register frees.
// Reset clears the gesture state and loads the register defaults
// (debounce 200 ms, min tap 50 ms, threshold 20, step 20).
module touch_gesture_classifier
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    localparam int IN_RAW    = 2 * COORD_BITS + TIME_BITS,
    localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = 2 * COORD_BITS + DUR_W + 1 + (COORD_BITS + 1) + MODE_W,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // touch_x, touch_y, now_ms
    input  logic [CMD_W-1:0]      s_tuser,   // command
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // tap_x, tap_y, tap_duration,
                                             // swipe_axis, swipe_steps, gesture_mode
    output logic [1:0]            m_tuser,   // tap_valid, swipe_valid
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int C = COORD_BITS;
    localparam int T = TIME_BITS;

    // Configuration registers
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [MIN_TAP_W-1:0]  min_tap_reg;
    logic [THRESH_W-1:0]   thresh_reg;
    logic [STEP_W-1:0]     step_reg;

    // Captured sample
    logic [CMD_W-1:0] cmd_reg;
    logic [C-1:0]     x_reg;
    logic [C-1:0]     y_reg;
    logic [T-1:0]     now_reg;

    // Gesture state
    logic [MODE_W-1:0] mode_reg;
    logic [C-1:0]      origin_x_reg;
    logic [C-1:0]      origin_y_reg;
    logic [C-1:0]      anchor_x_reg;
    logic [C-1:0]      anchor_y_reg;
    logic [T-1:0]      press_time_reg;
    logic              press_seen_reg;
    logic [T-1:0]      last_event_reg;
    logic              event_seen_reg;

    // Pending result
    logic              res_tap_valid_reg;
    logic [C-1:0]      res_tap_x_reg;
    logic [C-1:0]      res_tap_y_reg;
    logic [DUR_W-1:0]  res_dur_reg;
    logic              res_swipe_valid_reg;
    logic              res_axis_reg;
    logic [C:0]        res_steps_reg;

    // Swipe division context
    logic              div_neg_reg;
    logic [C-1:0]      div_pos_reg;

    // Output register
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    tgc_state_t state_reg, state_next;

    // Evaluate-cycle logic
    logic [T-1:0]   gap;
    logic [T-1:0]   held;
    logic           press_ok;
    logic           tap_ok;
    logic           dur_sat;
    logic [C:0]     sx, sy, ad, dd;
    logic [C-1:0]   ax, ay, aad, dmag;
    logic           moved;
    logic           lock_ok;
    logic [C-1:0]   pos, anch;
    logic           go_div;
    logic [STEP_W-1:0] step_eff;
    logic           out_free;

    logic           div_done;
    logic [C-1:0]   div_quot;
    logic [STEP_W-1:0] div_rem;

    assign gap      = now_reg - last_event_reg;
    assign held     = now_reg - press_time_reg;
    assign press_ok = !event_seen_reg || (gap > T'(debounce_reg));
    assign tap_ok   = (held > T'(min_tap_reg)) && (mode_reg != MODE_LR) &&
                      (mode_reg != MODE_UD);
    assign dur_sat  = 33'(held) > 33'(16'hFFFF);

    // Axis differences from the origin
    assign sx    = {1'b0, x_reg} - {1'b0, origin_x_reg};
    assign sy    = {1'b0, y_reg} - {1'b0, origin_y_reg};
    assign ax    = sx[C] ? C'(-sx) : sx[C-1:0];
    assign ay    = sy[C] ? C'(-sy) : sy[C-1:0];
    assign ad    = {1'b0, ax} - {1'b0, ay};
    assign aad   = ad[C] ? C'(-ad) : ad[C-1:0];
    assign moved = (sx != '0) || (sy != '0);
    assign lock_ok = 32'(aad) >= 32'(thresh_reg);

    // Offset along the locked axis from its anchor
    assign pos  = (mode_reg == MODE_LR) ? x_reg : y_reg;
    assign anch = (mode_reg == MODE_LR) ? anchor_x_reg : anchor_y_reg;
    assign dd   = {1'b0, pos} - {1'b0, anch};
    assign dmag = dd[C] ? C'(-dd) : dd[C-1:0];
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    assign go_div = (cmd_reg == CMD_MOVE) && press_seen_reg && moved &&
                    ((mode_reg == MODE_LR) || (mode_reg == MODE_UD));

    assign out_free = !m_tvalid_reg || m_tready;

    tgc_div #(
        .NUM_W (C),
        .DEN_W (STEP_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_EVAL && go_div),
        .num   (dmag),
        .den   (step_eff),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_EVAL;
            ST_EVAL:
                state_next = go_div ? ST_DIV : ST_EMIT;
            ST_DIV:
                if (div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            min_tap_reg  <= MIN_TAP_RST;
            thresh_reg   <= THRESH_RST;
            step_reg     <= STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                REG_MIN_TAP:  min_tap_reg  <= cfg_data[MIN_TAP_W-1:0];
                REG_THRESH:   thresh_reg   <= cfg_data[THRESH_W-1:0];
                REG_STEP:     step_reg     <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            x_reg   <= s_tdata[C-1:0];
            y_reg   <= s_tdata[2*C-1:C];
            now_reg <= s_tdata[2*C+T-1:2*C];
        end
    end

    // Gesture state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NONE;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            anchor_x_reg   <= '0;
            anchor_y_reg   <= '0;
            press_time_reg <= '0;
            press_seen_reg <= 1'b0;
            last_event_reg <= '0;
            event_seen_reg <= 1'b0;
        end
        else if (state_reg == ST_EVAL && cmd_reg != CMD_NONE)
        begin
            last_event_reg <= now_reg;
            event_seen_reg <= 1'b1;
            case (cmd_reg)
                CMD_PRESS:
                    if (press_ok)
                    begin
                        origin_x_reg   <= x_reg;
                        origin_y_reg   <= y_reg;
                        anchor_x_reg   <= x_reg;
                        anchor_y_reg   <= y_reg;
                        mode_reg       <= MODE_NONE;
                        press_time_reg <= now_reg;
                        press_seen_reg <= 1'b1;
                    end
                CMD_MOVE:
                    if (press_seen_reg && moved)
                    begin
                        if (mode_reg == MODE_NONE)
                            mode_reg <= MODE_DETECTED;
                        else if (mode_reg == MODE_DETECTED && lock_ok)
                            mode_reg <= (ax > ay) ? MODE_LR : MODE_UD;
                    end
                default: ;
            endcase
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            // anchor + steps * step equals pos minus the signed remainder
            if (!res_axis_reg)
                anchor_x_reg <= div_neg_reg ? C'(div_pos_reg + C'(div_rem))
                                            : C'(div_pos_reg - C'(div_rem));
            else
                anchor_y_reg <= div_neg_reg ? C'(div_pos_reg + C'(div_rem))
                                            : C'(div_pos_reg - C'(div_rem));
        end
    end

    // Pending result fields
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            res_tap_valid_reg   <= 1'b0;
            res_tap_x_reg       <= '0;
            res_tap_y_reg       <= '0;
            res_dur_reg         <= '0;
            res_swipe_valid_reg <= 1'b0;
            res_axis_reg        <= 1'b0;
            res_steps_reg       <= '0;
            div_neg_reg         <= dd[C];
            div_pos_reg         <= pos;
            if (cmd_reg == CMD_RELEASE && press_seen_reg && tap_ok)
            begin
                res_tap_valid_reg <= 1'b1;
                res_tap_x_reg     <= anchor_x_reg;
                res_tap_y_reg     <= anchor_y_reg;
                res_dur_reg       <= dur_sat ? 16'hFFFF : held[DUR_W-1:0];
            end
            if (go_div)
            begin
                res_swipe_valid_reg <= 1'b1;
                res_axis_reg        <= (mode_reg == MODE_UD);
            end
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            res_steps_reg <= div_neg_reg ? (C+1)'(-{1'b0, div_quot}) : {1'b0, div_quot};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == ST_EMIT && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            m_tdata_reg <= OUT_W'({mode_reg, res_steps_reg, res_axis_reg, res_dur_reg,
                                   res_tap_y_reg, res_tap_x_reg});
            m_tuser_reg <= {res_swipe_valid_reg, res_tap_valid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
